@@ rtl/core/bce_pkg.sv @@
// Package for the battery charge estimator.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none
package bce_pkg;

	localparam int VOLT_W     = 17;
	localparam int TIME_W     = 32;
	localparam int PCNT_W     = 16;
	localparam int MARGIN_W   = 16;
	localparam int PCT_W      = 7;
	localparam int DSR_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_VMIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VMAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd3;

	localparam logic [VOLT_W-1:0]   VMIN_RST   = 17'd42000;
	localparam logic [VOLT_W-1:0]   VMAX_RST   = 17'd52000;
	localparam logic [TIME_W-1:0]   PERIOD_RST = 32'd120000;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd1000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_BDIV,
		ST_PER,
		ST_MDIV,
		ST_MAP,
		ST_SDIV,
		ST_SLEW,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/battery_charge_estimator.sv @@
// Battery charge estimator top level: batch averaging, period mean and slew-limited mapping.
// Uses one shared restoring divider (one quotient bit per cycle) under a small sequencer;
// the batch average uses a constant reciprocal multiplication. Depends on bce_pkg.
// An item that completes no batch goes from ST_ACC to ST_DONE; one that completes a batch
// passes ST_BDIV and ST_PER, and one that updates the estimate goes on through ST_MDIV,
// ST_MAP, ST_SDIV (skipped for a bad range) and ST_SLEW before ST_DONE.
// One item is in work at a time; the next is taken once the result sits in the output register.
// Reset (arst_n low) clears all estimator state and loads the register defaults.
`default_nettype none
module battery_charge_estimator #(
	parameter int BATCH_SIZE = 5,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bce_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [bce_pkg::IN_DATA_W-1:0]    s_tdata,  // volt_mv[16:0], now_ms[48:17]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [bce_pkg::OUT_DATA_W-1:0]        m_tdata   // charge_percent[6:0], updated[7]
);
	import bce_pkg::*;

	localparam int CNT_W  = $clog2(BATCH_SIZE + 1);
	localparam int BSUM_W = VOLT_W + $clog2(BATCH_SIZE + 1);
	localparam int CHG_W  = PCT_W + FRAC_BITS;
	localparam int SCL_W  = PCT_W + FRAC_BITS;
	localparam int PROD_W = VOLT_W + SCL_W;
	localparam int DVD_A  = (PROD_W > TIME_W) ? PROD_W : TIME_W;
	localparam int DVD_W  = (BSUM_W > DVD_A) ? BSUM_W : DVD_A;
	localparam int DCNT_W = $clog2(DVD_W);
	localparam int REC_S  = BSUM_W + $clog2(BATCH_SIZE);
	localparam int BPRD_W = 2 * BSUM_W + 1;

	localparam logic [CHG_W-1:0]  ONE_Q   = CHG_W'(1 << FRAC_BITS);
	localparam logic [CHG_W-1:0]  TEN_Q   = CHG_W'(10 << FRAC_BITS);
	localparam logic [CHG_W-1:0]  MAX_Q   = CHG_W'(100 << FRAC_BITS);
	localparam logic [SCL_W-1:0]  SCALE_Q = SCL_W'(90 << FRAC_BITS);
	localparam logic [CNT_W-1:0]  BATCH_N = CNT_W'(BATCH_SIZE);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DVD_W - 1);
	localparam logic [BSUM_W:0]   REC_M = (BSUM_W + 1)'(((64'd1 << REC_S)
		+ 64'(BATCH_SIZE) - 64'd1) / 64'(BATCH_SIZE));

	state_t state_q, state_d;

	logic [VOLT_W-1:0]   vmin_q, vmax_q;
	logic [TIME_W-1:0]   period_q;
	logic [MARGIN_W-1:0] margin_q;

	logic [VOLT_W-1:0]   volt_q;
	logic [TIME_W-1:0]   now_q;
	logic [BSUM_W-1:0]   bsum_q;
	logic [CNT_W-1:0]    bcnt_q;
	logic [TIME_W-1:0]   psum_q;
	logic [PCNT_W-1:0]   pcnt_q;
	logic [TIME_W-1:0]   pstart_q;
	logic                first_q;
	logic [CHG_W-1:0]    last_q;
	logic                upd_q;

	logic [DSR_W-1:0]    rem_q;
	logic [DVD_W-1:0]    quo_q;
	logic [DSR_W-1:0]    dsr_q;
	logic [DCNT_W-1:0]   dcnt_q;

	logic                         m_tvalid_q;
	logic [OUT_DATA_W-1:0]        m_tdata_q;

	logic                accept_ok, batch_full, avg_pos, due, do_update, bad_range;
	logic                div_load, div_step, out_free;
	logic [DVD_W-1:0]    div_dvd;
	logic [DSR_W-1:0]    div_dsr;
	logic [BSUM_W-1:0]   bsum_new;
	logic [CNT_W-1:0]    bcnt_new;
	logic [BPRD_W-1:0]   bprod;
	logic [VOLT_W-1:0]   bavg;
	logic [VOLT_W-1:0]   avg;
	logic [TIME_W:0]     psum_add;
	logic [TIME_W-1:0]   psum_new, elapsed, mean;
	logic [PCNT_W-1:0]   pcnt_new;
	logic [VOLT_W-1:0]   vclamp, diff, span;
	logic [PROD_W-1:0]   prod;
	logic [CHG_W-1:0]    raw, slew_val;
	logic [DSR_W:0]      trial, trial_sub;
	logic                trial_ge;

	always_comb begin
		accept_ok = ({1'b0, volt_q} + {2'b00, margin_q}) >= {1'b0, vmin_q};
		bsum_new  = bsum_q + BSUM_W'(volt_q);
		bcnt_new  = bcnt_q + CNT_W'(1);
		batch_full = bcnt_new >= BATCH_N;

		bprod = BPRD_W'(quo_q[BSUM_W-1:0]) * BPRD_W'(REC_M);
		bavg  = bprod[REC_S +: VOLT_W];

		avg      = quo_q[VOLT_W-1:0];
		avg_pos  = |avg;
		psum_add = {1'b0, psum_q} + (TIME_W + 1)'(avg);
		psum_new = psum_q;
		pcnt_new = pcnt_q;
		if (avg_pos) begin
			psum_new = psum_add[TIME_W] ? '1 : psum_add[TIME_W-1:0];
			if (pcnt_q != '1) begin
				pcnt_new = pcnt_q + PCNT_W'(1);
			end
		end
		elapsed   = now_q - pstart_q;
		due       = first_q || (elapsed >= period_q);
		do_update = due && (pcnt_new != '0);

		mean      = quo_q[TIME_W-1:0];
		bad_range = vmax_q <= vmin_q;
		if (mean < TIME_W'(vmin_q)) begin
			vclamp = vmin_q;
		end else if (mean > TIME_W'(vmax_q)) begin
			vclamp = vmax_q;
		end else begin
			vclamp = mean[VOLT_W-1:0];
		end
		diff = vclamp - vmin_q;
		span = vmax_q - vmin_q;
		prod = PROD_W'(diff) * PROD_W'(SCALE_Q);

		raw      = TEN_Q + quo_q[CHG_W-1:0];
		slew_val = raw;
		if (last_q >= ONE_Q) begin
			if (last_q > raw && (last_q - raw) > ONE_Q) begin
				slew_val = last_q - ONE_Q;
			end else if (raw > last_q && (raw - last_q) > ONE_Q) begin
				slew_val = last_q + ONE_Q;
			end
		end

		trial     = {rem_q, quo_q[DVD_W-1]};
		trial_ge  = trial >= {1'b0, dsr_q};
		trial_sub = trial - {1'b0, dsr_q};
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		div_load = 1'b0;
		div_dvd  = '0;
		div_dsr  = '0;
		div_step = 1'b0;
		out_free = !m_tvalid_q || m_tready;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (accept_ok && batch_full) begin
					div_load = 1'b1;
					div_dvd  = DVD_W'(bsum_new);
					state_d  = ST_BDIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_BDIV: begin
				div_load = 1'b1;
				div_dvd  = DVD_W'(bavg);
				state_d  = ST_PER;
			end
			ST_PER: begin
				if (do_update) begin
					div_load = 1'b1;
					div_dvd  = DVD_W'(psum_new);
					div_dsr  = DSR_W'(pcnt_new);
					state_d  = ST_MDIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MDIV: begin
				div_step = 1'b1;
				if (dcnt_q == '0) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				div_load = 1'b1;
				div_dsr  = span;
				if (bad_range) begin
					div_dvd = '0;
					state_d = ST_SLEW;
				end else begin
					div_dvd = DVD_W'(prod);
					state_d = ST_SDIV;
				end
			end
			ST_SDIV: begin
				div_step = 1'b1;
				if (dcnt_q == '0) begin
					state_d = ST_SLEW;
				end
			end
			ST_SLEW: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q     <= VMIN_RST;
			vmax_q     <= VMAX_RST;
			period_q   <= PERIOD_RST;
			margin_q   <= MARGIN_RST;
			bsum_q     <= '0;
			bcnt_q     <= '0;
			psum_q     <= '0;
			pcnt_q     <= '0;
			pstart_q   <= '0;
			first_q    <= 1'b1;
			last_q     <= '0;
			upd_q      <= 1'b0;
			dcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_VMIN:   vmin_q   <= cfg_data[VOLT_W-1:0];
					REG_VMAX:   vmax_q   <= cfg_data[VOLT_W-1:0];
					REG_PERIOD: period_q <= cfg_data[TIME_W-1:0];
					REG_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
					default: begin
					end
				endcase
			end
			if (div_load) begin
				dcnt_q <= DCNT_LAST;
			end else if (div_step) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					upd_q <= 1'b0;
					if (accept_ok) begin
						if (batch_full) begin
							bsum_q <= '0;
							bcnt_q <= '0;
						end else begin
							bsum_q <= bsum_new;
							bcnt_q <= bcnt_new;
						end
					end
				end
				ST_PER: begin
					if (do_update) begin
						psum_q   <= '0;
						pcnt_q   <= '0;
						first_q  <= 1'b0;
						pstart_q <= now_q;
					end else begin
						psum_q <= psum_new;
						pcnt_q <= pcnt_new;
					end
				end
				ST_SLEW: begin
					last_q <= slew_val;
					upd_q  <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			volt_q <= s_tdata[VOLT_W-1:0];
			now_q  <= s_tdata[VOLT_W +: TIME_W];
		end
		if (div_load) begin
			rem_q <= '0;
			quo_q <= div_dvd;
			dsr_q <= div_dsr;
		end else if (div_step) begin
			rem_q <= trial_ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], trial_ge};
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {upd_q, last_q[FRAC_BITS +: PCT_W]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_charge_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_q <= MAX_Q)
		else $error("charge estimate above full scale");

	a_first_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLEW) |-> !first_q)
		else $error("first update still pending at slew step");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_step |-> (rem_q < dsr_q))
		else $error("divider remainder not below divisor");

	a_batch_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q < BATCH_N)
		else $error("batch count reached batch size");

	a_update_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLEW) |=> upd_q && (state_q == ST_DONE))
		else $error("update flag not set after new estimate");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for battery_charge_estimator: voltage samples stream in and
// every charge result is checked against a cycle-free predictor kept in a scoreboard class.
// Depends on bce_pkg and the battery_charge_estimator RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bce_pkg::*;

	localparam int BATCH        = 5;
	localparam int FRAC         = 8;
	localparam int ONE_PCT      = 1 << FRAC;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 120;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic             upd;
		logic [PCT_W-1:0] pct;
	} result_t;

	class charge_scoreboard;
		logic [VOLT_W-1:0]   vmin;
		logic [VOLT_W-1:0]   vmax;
		logic [TIME_W-1:0]   period;
		logic [MARGIN_W-1:0] margin;
		logic [19:0]         batch_sum;
		logic [2:0]          batch_cnt;
		logic [TIME_W-1:0]   psum;
		logic [PCNT_W-1:0]   pcnt;
		logic [TIME_W-1:0]   pstart;
		bit                  first;
		logic [14:0]         charge_q;
		result_t             pending[$];
		int                  errors;

		function new();
			vmin      = VMIN_RST;
			vmax      = VMAX_RST;
			period    = PERIOD_RST;
			margin    = MARGIN_RST;
			batch_sum = '0;
			batch_cnt = '0;
			psum      = '0;
			pcnt      = '0;
			pstart    = '0;
			first     = 1'b1;
			charge_q  = '0;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_VMIN:   vmin = data[VOLT_W-1:0];
				REG_VMAX:   vmax = data[VOLT_W-1:0];
				REG_PERIOD: period = data;
				REG_MARGIN: margin = data[MARGIN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] map_level(logic [31:0] mean);
			logic [31:0] v;
			logic [31:0] span;
			logic [63:0] scaled;
			if (vmax <= vmin)
				return 32'(10 * ONE_PCT);
			v = mean;
			if (v < 32'(vmin))
				v = 32'(vmin);
			if (v > 32'(vmax))
				v = 32'(vmax);
			span = 32'(vmax) - 32'(vmin);
			scaled = 64'(v - 32'(vmin)) * 64'(90 * ONE_PCT) / 64'(span);
			return 32'(10 * ONE_PCT) + scaled[31:0];
		endfunction

		function void note_input(logic [VOLT_W-1:0] volt, logic [TIME_W-1:0] now);
			result_t     res;
			logic [31:0] avg;
			logic [31:0] raw;
			logic [31:0] elapsed;
			logic [31:0] level;
			res.upd = 1'b0;
			if (int'(volt) + int'(margin) >= int'(vmin)) begin
				batch_sum = batch_sum + 20'(volt);
				batch_cnt = batch_cnt + 3'd1;
				if (batch_cnt >= BATCH) begin
					avg = 32'(batch_sum) / BATCH;
					batch_sum = '0;
					batch_cnt = '0;
					if (avg != 0) begin
						if (33'(psum) + 33'(avg) > 33'hFFFF_FFFF)
							psum = '1;
						else
							psum = psum + avg;
						if (pcnt != '1)
							pcnt = pcnt + PCNT_W'(1);
					end
					elapsed = now - pstart;
					if ((first || elapsed >= period) && pcnt != 0) begin
						raw = map_level(psum / 32'(pcnt));
						level = 32'(charge_q);
						if (level >= ONE_PCT) begin
							if (level > raw && level - raw > ONE_PCT)
								raw = level - ONE_PCT;
							else if (raw > level && raw - level > ONE_PCT)
								raw = level + ONE_PCT;
						end
						charge_q = raw[14:0];
						psum     = '0;
						pcnt     = '0;
						first    = 1'b0;
						pstart   = now;
						res.upd  = 1'b1;
					end
				end
			end
			res.pct = PCT_W'(charge_q >> FRAC);
			pending.push_back(res);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			result_t got;
			result_t want;
			got = data;
			if (pending.size() == 0) begin
				flag($sformatf("unexpected result pct %0d updated %0d", got.pct, got.upd));
				return;
			end
			want = pending.pop_front();
			if (got.pct != want.pct)
				flag($sformatf("charge_percent expected %0d got %0d", want.pct, got.pct));
			if (got.upd != want.upd)
				flag($sformatf("updated expected %0d got %0d", want.upd, got.upd));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // volt_mv[16:0], now_ms[48:17]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // charge_percent[6:0], updated[7]

	charge_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	battery_charge_estimator #(
		.BATCH_SIZE(BATCH),
		.FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL battery_charge_estimator");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	initial begin
		int pause;
		@(posedge clk);
		forever begin
			pause = quiet ? 0 : $urandom_range(0, 3);
			if (hold_req) begin
				hold_req = 1'b0;
				pause = HOLD_CYCLES;
			end
			if (pause != 0) begin
				m_tready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_sample(input logic [VOLT_W-1:0] volt, input logic [TIME_W-1:0] now);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, now, volt};
		do @(posedge clk); while (!s_tready);
		sb.note_input(volt, now);
	endtask

	task automatic wait_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	initial begin
		int unsigned settings [PHASES][4];
		int r;
		int lo;
		int hi;
		int ext;
		int thr;
		logic [VOLT_W-1:0] volt;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] step;

		settings = '{
			'{42000, 52000, 120000, 1000},
			'{0, 131071, 1, 0},
			'{131071, 1, 32'hFFFF_FFFF, 65535},
			'{50000, 50000, 30000, 0},
			'{1000, 2000, 5000, 65535},
			'{0, 1, 1000, 0},
			'{100000, 131071, 60000, 30000},
			'{42000, 52000, 120000, 1000}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: first update, rejects at the threshold edge, a slew step down, an
		// update just before the time wrap and a batch after the wrap that comes too early to update.
		for (int k = 0; k < 5; k++)
			send_sample('1, TIME_W'(k));
		send_sample('0, 32'd10);
		send_sample(17'd40999, 32'd11);
		send_sample(17'd41000, 32'd12);
		for (int k = 0; k < 4; k++)
			send_sample(17'd41000, 32'd13);
		for (int k = 0; k < 5; k++)
			send_sample(17'd42000, 32'd200000);
		for (int k = 0; k < 5; k++)
			send_sample(17'd47000, 32'hFFFF_FFF0);
		for (int k = 0; k < 5; k++)
			send_sample('1, 32'h10);
		s_tvalid <= 1'b0;

		t = 32'd300000;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			write_reg(REG_VMIN, settings[ph][0]);
			write_reg(REG_VMAX, settings[ph][1]);
			write_reg(REG_PERIOD, settings[ph][2]);
			write_reg(REG_MARGIN, settings[ph][3]);
			cfg_wr_en <= 1'b0;
			@(posedge clk);

			quiet = (ph == 3);
			if (ph == 1 || ph == 6)
				hold_req = 1'b1;
			if (ph == PHASES - 1)
				t = 32'hFFFF_0000;

			lo = (sb.vmin < sb.vmax) ? int'(sb.vmin) : int'(sb.vmax);
			hi = (sb.vmin < sb.vmax) ? int'(sb.vmax) : int'(sb.vmin);
			ext = (hi - lo) / 8 + 2;
			lo = (lo > ext) ? lo - ext : 0;
			hi = (hi + ext > 131071) ? 131071 : hi + ext;
			step = sb.period / 3 + 2;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					volt = VOLT_W'($urandom_range(0, 131071));
				end else if (r < 14) begin
					volt = r[0] ? '1 : '0;
				end else if (r < 22) begin
					thr = int'(sb.vmin) - int'(sb.margin) + int'($urandom_range(0, 4)) - 2;
					volt = (thr < 0) ? '0 : (thr > 131071) ? '1 : VOLT_W'(thr);
				end else begin
					volt = VOLT_W'($urandom_range(lo, hi));
				end

				r = $urandom_range(0, 99);
				if (r < 5) begin
					now = $urandom;
				end else if (r < 12) begin
					now = sb.pstart + sb.period + TIME_W'($urandom_range(0, 2)) - 32'd1;
				end else begin
					t = t + TIME_W'($urandom_range(0, step));
					now = t;
				end
				send_sample(volt, now);
			end
			s_tvalid <= 1'b0;
		end
		quiet = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS battery_charge_estimator");
		else
			$display("FAIL battery_charge_estimator");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/bce_pkg.sv
rtl/core/battery_charge_estimator.sv
verif/tb_top.sv
